/* sv/ctt_pkg.sv */
// Package for the configuration text tokenizer: token kinds, lexer modes,
// character constants and the result record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctt_pkg;

    localparam logic [1:0] KIND_ATOM  = 2'd0;
    localparam logic [1:0] KIND_STR   = 2'd1;
    localparam logic [1:0] KIND_PUNCT = 2'd2;
    localparam logic [1:0] KIND_EOI   = 2'd3;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_ATOM    = 3'd2;
    localparam logic [2:0] MODE_STR     = 3'd3;
    localparam logic [2:0] MODE_ESC     = 3'd4;

    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Most results one text byte can cause.
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       ch_valid;
        logic       tok_end;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_LBRACE) || (c == CH_RBRACE);
    endfunction

endpackage

`default_nettype wire

/* sv/config_text_tokenizer_top.sv */
// An accepted byte waits in the input register, then its results load the result
// register. Throughput: one byte per cycle while each byte gives at most one
// result and results are taken; a byte that gives several results holds the
// result register, one result a cycle while they are taken. The input register
// takes the next byte while a result still waits downstream. Reset (synchronous,
// active low) empties both registers and returns the lexer to idle between tokens.
`timescale 1ns / 1ps
`default_nettype none

module config_text_tokenizer_top
    import ctt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_token_kind,
    output logic [7:0]      o_char_out,
    output logic            o_char_valid,
    output logic            o_token_end,
    output logic            o_run_last
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;

    // Lexer state.
    logic [2:0] r_mode;
    logic [2:0] n_mode;

    // Result register: all results of one byte, drained one per cycle while taken.
    logic       r_pend_valid;
    logic [1:0] r_idx;
    logic [1:0] r_cnt;
    t_result    r_res [MAX_RESULTS];
    t_result    n_res [MAX_RESULTS];
    logic [1:0] n_cnt;

    logic       out_fire;
    logic       advance;
    t_result    cur;

    always_comb begin
        logic do_start;
        do_start = 1'b0;
        n_mode   = r_mode;
        n_cnt    = 2'd0;
        for (int j = 0; j < MAX_RESULTS; j++) begin
            n_res[j] = '0;
        end

        case (r_mode)
            MODE_COMMENT: begin
                if (r_char == CH_NEWLINE) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_ATOM: begin
                if (is_ws(r_char) || is_punct(r_char) || r_char == CH_HASH) begin
                    n_res[n_cnt] = '{kind: KIND_ATOM, ch: 8'h00, ch_valid: 1'b0, tok_end: 1'b1};
                    n_cnt = n_cnt + 2'd1;
                    do_start = 1'b1;
                end else begin
                    n_res[n_cnt] = '{kind: KIND_ATOM, ch: r_char, ch_valid: 1'b1, tok_end: 1'b0};
                    n_cnt = n_cnt + 2'd1;
                end
            end
            MODE_STR: begin
                if (r_char == CH_QUOTE) begin
                    n_res[n_cnt] = '{kind: KIND_STR, ch: 8'h00, ch_valid: 1'b0, tok_end: 1'b1};
                    n_cnt = n_cnt + 2'd1;
                    n_mode = MODE_IDLE;
                end else if (r_char == CH_BACKSLASH && !r_last) begin
                    n_mode = MODE_ESC;
                end else begin
                    n_res[n_cnt] = '{kind: KIND_STR, ch: r_char, ch_valid: 1'b1, tok_end: 1'b0};
                    n_cnt = n_cnt + 2'd1;
                end
            end
            MODE_ESC: begin
                n_res[n_cnt] = '{kind: KIND_STR, ch: r_char, ch_valid: 1'b1, tok_end: 1'b0};
                n_cnt = n_cnt + 2'd1;
                n_mode = MODE_STR;
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        // A byte seen between tokens, or the byte that ended an atom.
        if (do_start) begin
            if (is_ws(r_char)) begin
                n_mode = MODE_IDLE;
            end else if (r_char == CH_HASH) begin
                n_mode = MODE_COMMENT;
            end else if (r_char == CH_QUOTE) begin
                n_mode = MODE_STR;
            end else if (is_punct(r_char)) begin
                n_res[n_cnt] = '{kind: KIND_PUNCT, ch: r_char, ch_valid: 1'b1, tok_end: 1'b1};
                n_cnt = n_cnt + 2'd1;
                n_mode = MODE_IDLE;
            end else begin
                n_res[n_cnt] = '{kind: KIND_ATOM, ch: r_char, ch_valid: 1'b1, tok_end: 1'b0};
                n_cnt = n_cnt + 2'd1;
                n_mode = MODE_ATOM;
            end
        end

        // End of text closes whatever token is open, then marks end of input.
        if (r_last) begin
            if (n_mode == MODE_ATOM) begin
                n_res[n_cnt] = '{kind: KIND_ATOM, ch: 8'h00, ch_valid: 1'b0, tok_end: 1'b1};
                n_cnt = n_cnt + 2'd1;
            end else if (n_mode == MODE_STR || n_mode == MODE_ESC) begin
                n_res[n_cnt] = '{kind: KIND_STR, ch: 8'h00, ch_valid: 1'b0, tok_end: 1'b1};
                n_cnt = n_cnt + 2'd1;
            end
            n_res[n_cnt] = '{kind: KIND_EOI, ch: 8'h00, ch_valid: 1'b0, tok_end: 1'b1};
            n_cnt = n_cnt + 2'd1;
            n_mode = MODE_IDLE;
        end
    end

    assign cur          = r_res[r_idx];
    assign o_out_valid  = r_pend_valid;
    assign o_token_kind = cur.kind;
    assign o_char_out   = cur.ch;
    assign o_char_valid = cur.ch_valid;
    assign o_token_end  = cur.tok_end;
    assign o_run_last   = (r_idx == r_cnt - 2'd1);

    assign out_fire   = r_pend_valid && i_out_ready;
    // The held byte moves on once the result register is empty or being emptied.
    assign advance    = r_in_valid && (!r_pend_valid || (out_fire && o_run_last));
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_idx        <= 2'd0;
            r_mode       <= MODE_IDLE;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            // Loading the next byte's results takes over from draining the last one.
            if (advance) begin
                r_pend_valid <= (n_cnt != 2'd0);
                r_idx        <= 2'd0;
                r_mode       <= n_mode;
            end else if (out_fire) begin
                if (o_run_last) begin
                    r_pend_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_in;
            r_last <= i_last_byte;
        end
        if (advance) begin
            r_cnt <= n_cnt;
            r_res <= n_res;
        end
    end

`ifndef SYNTHESIS
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_cnt != 2'd0))
        else $error("result register holds no results");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_idx < r_cnt))
        else $error("result index past result count");

    a_eoi_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == KIND_EOI) |-> (o_token_end && o_run_last))
        else $error("end-of-input result not final");

    a_marker_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_char_valid) |-> (o_token_end && o_char_out == 8'h00))
        else $error("byteless result is not a clean close marker");

    a_hold_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_pend_valid && !out_fire) |-> !o_in_ready)
        else $error("input taken while held byte cannot move");
`endif

endmodule

`default_nettype wire

/* tb/config_text_tokenizer_top_test.sv */
// Self-checking testbench for config_text_tokenizer_top: directed and random text bytes,
// with the expected tokens predicted inside the bench and compared field by field.
// Depends on ctt_pkg and config_text_tokenizer_top.
`timescale 1ns / 1ps

module config_text_tokenizer_top_test;
    import ctt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 300;
    localparam int DRAIN_WAIT  = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_byte;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       ch_valid;
        logic       tok_end;
        logic       run_last;
    } t_token_res;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] char_in   = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_ready = 1'b0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_token_kind;
    logic [7:0] o_char_out;
    logic       o_char_valid;
    logic       o_token_end;
    logic       o_run_last;

    t_text_byte text_q[$];
    t_token_res token_q[$];
    t_token_res step_res[$];
    logic [2:0] lex_mode = MODE_IDLE;

    int send_idle = 0;
    int recv_idle = 0;
    int errors = 0;
    int bytes_sent = 0;
    int rand_bytes = 0;
    int texts_made = 0;
    int results_checked = 0;
    int cycle_count = 0;

    config_text_tokenizer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_in    (char_in),
        .i_last_byte  (last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_token_kind (o_token_kind),
        .o_char_out   (o_char_out),
        .o_char_valid (o_char_valid),
        .o_token_end  (o_token_end),
        .o_run_last   (o_run_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- token prediction ----------------

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic punct_char(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_LBRACE) || (c == CH_RBRACE);
    endfunction

    function automatic void add_res(input logic [1:0] kind, input logic [7:0] c,
                                    input logic v, input logic e);
        t_token_res r;
        r.kind     = kind;
        r.ch       = v ? c : 8'h00;
        r.ch_valid = v;
        r.tok_end  = e;
        r.run_last = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void begin_token(input logic [7:0] c);
        if (blank_char(c)) begin
            lex_mode = MODE_IDLE;
        end else if (c == CH_HASH) begin
            lex_mode = MODE_COMMENT;
        end else if (c == CH_QUOTE) begin
            lex_mode = MODE_STR;
        end else if (punct_char(c)) begin
            add_res(KIND_PUNCT, c, 1'b1, 1'b1);
            lex_mode = MODE_IDLE;
        end else begin
            add_res(KIND_ATOM, c, 1'b1, 1'b0);
            lex_mode = MODE_ATOM;
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c, input logic last);
        step_res.delete();
        case (lex_mode)
            MODE_COMMENT: begin
                if (c == CH_NEWLINE)
                    lex_mode = MODE_IDLE;
            end
            MODE_ATOM: begin
                if (blank_char(c) || punct_char(c) || c == CH_HASH) begin
                    add_res(KIND_ATOM, 8'h00, 1'b0, 1'b1);
                    begin_token(c);
                end else begin
                    add_res(KIND_ATOM, c, 1'b1, 1'b0);
                end
            end
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    add_res(KIND_STR, 8'h00, 1'b0, 1'b1);
                    lex_mode = MODE_IDLE;
                end else if (c == CH_BACKSLASH && !last) begin
                    lex_mode = MODE_ESC;
                end else begin
                    add_res(KIND_STR, c, 1'b1, 1'b0);
                end
            end
            MODE_ESC: begin
                add_res(KIND_STR, c, 1'b1, 1'b0);
                lex_mode = MODE_STR;
            end
            default: begin_token(c);
        endcase
        // The end of the text closes whatever is still open, then marks end of input.
        if (last) begin
            if (lex_mode == MODE_ATOM)
                add_res(KIND_ATOM, 8'h00, 1'b0, 1'b1);
            else if (lex_mode == MODE_STR || lex_mode == MODE_ESC)
                add_res(KIND_STR, 8'h00, 1'b0, 1'b1);
            add_res(KIND_EOI, 8'h00, 1'b0, 1'b1);
            lex_mode = MODE_IDLE;
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].run_last = 1'b1;
        foreach (step_res[i])
            token_q.push_back(step_res[i]);
    endfunction

    // ---------------- stimulus ----------------

    function automatic void push_byte(input logic [7:0] c, input logic last);
        t_text_byte b;
        b.ch   = c;
        b.last = last;
        text_q.push_back(b);
    endfunction

    function automatic void push_str(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], ends && (i == s.len() - 1));
    endfunction

    // A byte that continues or starts an atom.
    function automatic logic [7:0] atom_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (blank_char(c) || punct_char(c) || c == CH_HASH || c == CH_QUOTE)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] str_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BACKSLASH)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] blank_pick();
        logic [7:0] blanks[6];
        blanks = '{CH_SPACE, CH_TAB, CH_NEWLINE, 8'h0B, 8'h0C, CH_CR};
        return blanks[$urandom_range(0, 5)];
    endfunction

    // One text made mostly of well-formed tokens, with some stray bytes and
    // unterminated strings; its final byte carries the last flag.
    function automatic void add_text();
        logic [7:0] txt[$];
        logic [7:0] puncts[3];
        int n_tok;
        int pick;
        int len;
        puncts = '{CH_COMMA, CH_LBRACE, CH_RBRACE};
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++) begin
            pick = $urandom_range(0, 9);
            len = $urandom_range(0, 5);
            if (pick <= 2) begin
                txt.push_back(atom_char());
                for (int k = 0; k < len; k++)
                    txt.push_back(($urandom_range(0, 9) == 0) ? CH_QUOTE : atom_char());
            end else if (pick <= 4) begin
                txt.push_back(CH_QUOTE);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        txt.push_back(CH_BACKSLASH);
                        txt.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        txt.push_back(str_char());
                    end
                end
                if ($urandom_range(0, 9) != 0)
                    txt.push_back(CH_QUOTE);
            end else if (pick <= 6) begin
                txt.push_back(puncts[$urandom_range(0, 2)]);
            end else if (pick == 7) begin
                txt.push_back(CH_HASH);
                for (int k = 0; k < len; k++)
                    txt.push_back(str_char() == CH_NEWLINE ? CH_SPACE : str_char());
                if ($urandom_range(0, 4) != 0)
                    txt.push_back(CH_NEWLINE);
            end else begin
                txt.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) < 6)
                txt.push_back(blank_pick());
        end
        foreach (txt[i])
            push_byte(txt[i], i == txt.size() - 1);
        rand_bytes += txt.size();
        texts_made++;
    endfunction

    // ---------------- driver and monitor ----------------

    always @(posedge i_clk) begin : drive_text
        t_text_byte nxt;
        logic holding;
        holding = in_valid;
        if (in_valid && o_in_ready) begin
            tokenize_byte(char_in, last_byte);
            bytes_sent++;
            holding = 1'b0;
        end
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!holding) begin
            if (text_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                nxt = text_q.pop_front();
                in_valid  <= 1'b1;
                char_in   <= nxt.ch;
                last_byte <= nxt.last;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    function automatic void report(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
    endfunction

    always @(posedge i_clk) begin : watch_tokens
        t_token_res want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (token_q.size() == 0) begin
                $display("%0t: result with none expected, kind %0h char %0h", $time,
                         o_token_kind, o_char_out);
                errors++;
            end else begin
                want = token_q.pop_front();
                results_checked++;
                if (o_token_kind !== want.kind)
                    report("token_kind", 8'(want.kind), 8'(o_token_kind));
                if (o_char_out !== want.ch)
                    report("char_out", want.ch, o_char_out);
                if (o_char_valid !== want.ch_valid)
                    report("char_valid", 8'(want.ch_valid), 8'(o_char_valid));
                if (o_token_end !== want.tok_end)
                    report("token_end", 8'(want.tok_end), 8'(o_token_end));
                if (o_run_last !== want.run_last)
                    report("run_last", 8'(want.run_last), 8'(o_run_last));
            end
        end
        out_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("config_text_tokenizer_top_test failed");
            $finish;
        end
    end

    // ---------------- sequencing ----------------

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts: byte extremes, every token kind, and the closing rules.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_str(",{x#\n", 1'b0);        // punctuation, then an atom closed by a comment
        push_str("z}", 1'b1);            // close, punctuation and end of input on one byte
        push_str("\"a\\\"\"", 1'b0);     // escaped quote inside a string
        push_str("\"\\", 1'b1);          // backslash as the last byte stays literal
        push_str("\"\\q", 1'b1);         // escape completed by the last byte of the text
        push_str("\"", 1'b1);            // string holding only its opening quote
        push_str("#z", 1'b1);            // comment still open at the end
        push_str("a\" b", 1'b1);         // quote inside an atom, atom closed by a space

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 22 : (ph == 1) ? 61 : 0;
            recv_idle = (ph == 0) ? 61 : (ph == 1) ? 22 : 0;
            while (rand_bytes < (ph + 1) * RAND_ITEMS / 3)
                add_text();
            // The sender holds off here until every predicted result has arrived.
            while (text_q.size() > 0 || in_valid || token_q.size() > 0)
                @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Summary: %0d bytes sent (%0d in %0d random texts), %0d results checked.",
                 bytes_sent, rand_bytes, texts_made, results_checked);
        $display("Stalls were applied on each side in turn, then a stall-free stretch.");
        if (errors == 0 && token_q.size() == 0) begin
            $display("config_text_tokenizer_top_test passed");
        end else begin
            $display("config_text_tokenizer_top_test failed");
        end
        $finish;
    end

endmodule
